// ===== hw/rtl/pbc_pkg.sv =====
// Shared types, constants and helpers of the disc collision block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package pbc_pkg;

  // Widths of the result fields that carry an index and a count.
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  // Discs reported by one tick at most.
  localparam int REPORT_MAX = 16;

  // Direction components are scaled down until both lie below this limit.
  localparam int DIR_LIMIT = 16384;

  // Input item kinds, carried on tuser.
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BOUND_LEFT     = 3'd0,
    CFG_BOUND_TOP      = 3'd1,
    CFG_BOUND_WIDTH    = 3'd2,
    CFG_BOUND_HEIGHT   = 3'd3,
    CFG_DEFAULT_RADIUS = 3'd4
  } cfg_reg_t;

  // One stored disc.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        r;
  } disc_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_MUL_POS,
    OP_ADD_POS,
    OP_WALL1,
    OP_WALL2,
    OP_WALL3,
    OP_DIFF,
    OP_MAG,
    OP_GATE,
    OP_SQ_S,
    OP_SQ_X,
    OP_SQ_Y,
    OP_CONTACT,
    OP_NORM,
    OP_DIR,
    OP_N1,
    OP_N2,
    OP_N3,
    OP_P1,
    OP_P2,
    OP_KMUL,
    OP_DIV,
    OP_APPLY
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_t             op;
    logic               axis;       // 0 selects x, 1 selects y
    logic               wr_b;       // write disc B instead of disc A
    logic               emit;
    logic               emit_zero;  // emit zero centre and velocity
    logic [IDX_W-1:0]   emit_idx;
    logic [CNT_W-1:0]   emit_cnt;
    logic               emit_rej;
    logic               emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic far;
    logic norm_busy;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] res;
    if (v > 72'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbc_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none

module pbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; used by the datapath for the collision impulse.
`default_nettype none

module pbc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic [28:0]        den,
  output logic                    busy,
  output logic signed [63:0]      quo
);

  logic [6:0]  cnt;
  logic [28:0] rem;
  logic [63:0] mag;
  logic        neg;
  logic [29:0] den_r;
  logic [29:0] shifted;
  logic [29:0] diff;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted = {rem, mag[63]};
  assign diff    = shifted - den_r;

  // Control: sixty-four shift steps, then one sign fix step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
    end else if (busy) begin
      if (cnt != 7'd0) begin
        cnt <= cnt - 7'd1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[63];
      mag   <= num[63] ? 64'(-num) : 64'(num);
      rem   <= '0;
      den_r <= {1'b0, den};
    end else if (busy) begin
      if (cnt != 7'd0) begin
        if (shifted >= den_r) begin
          rem <= diff[28:0];
          mag <= {mag[62:0], 1'b1};
        end else begin
          rem <= shifted[28:0];
          mag <= {mag[62:0], 1'b0};
        end
      end else begin
        quo <= neg ? $signed(-mag) : $signed(mag);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbc_datapath.sv =====
// Datapath of the disc collision block: configuration, disc store, arithmetic
// and the result register. Depends on pbc_pkg, pbc_ram and pbc_div.
`default_nettype none

module pbc_datapath #(
  parameter int MAX_DISCS = 16,
  localparam int IW = (MAX_DISCS > 1) ? $clog2(MAX_DISCS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic [30:0]        radius,
  input  wire logic [15:0]        elapsed_ms,
  input  wire pbc_pkg::dp_cmd_t   cmd,
  output pbc_pkg::dp_stat_t       stat,
  input  wire logic [IW-1:0]      ram_addr,
  input  wire logic               ram_we,
  input  wire logic               ram_re,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [143:0]            m_tdata,
  output logic                    m_tuser,
  output logic                    m_tlast
);

  // Configuration registers.
  logic signed [31:0] bound_left;
  logic signed [31:0] bound_top;
  logic [30:0]        bound_width;
  logic [30:0]        bound_height;
  logic [30:0]        default_radius;

  // Working discs and scratch registers.
  pbc_pkg::disc_t     a;
  pbc_pkg::disc_t     b;
  pbc_pkg::disc_t     ram_wdata;
  pbc_pkg::disc_t     ram_rdata;
  logic [15:0]        elapsed;
  logic signed [65:0] prod;
  logic signed [33:0] w_lo;
  logic signed [33:0] w_hi;
  logic signed [33:0] w_bnd;
  logic signed [33:0] w_bh;
  logic signed [35:0] w_d;
  logic               w_under;
  logic               w_over;
  logic signed [32:0] d_x;
  logic signed [32:0] d_y;
  logic signed [32:0] dv_x;
  logic signed [32:0] dv_y;
  logic [31:0]        r_sum;
  logic [32:0]        m_x;
  logic [32:0]        m_y;
  logic [63:0]        sq_s;
  logic [63:0]        sq_a;
  logic               skip;
  logic               far;
  logic signed [14:0] u_x;
  logic signed [14:0] u_y;
  logic [27:0]        n_a;
  logic [28:0]        n;
  logic signed [47:0] p_a;
  logic signed [48:0] p;
  logic signed [63:0] kn;
  logic               div_busy;
  logic signed [63:0] quo;

  // Axis selections.
  logic signed [31:0] c_sel;
  logic signed [31:0] v_sel;
  logic signed [31:0] bnd_sel;
  logic [30:0]        span_sel;
  logic signed [14:0] u_sel;

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bound_left     <= '0;
      bound_top      <= '0;
      bound_width    <= 31'd52428800;
      bound_height   <= 31'd39321600;
      default_radius <= 31'd655360;
    end else if (cfg_wr_en) begin
      case (pbc_pkg::cfg_reg_t'(cfg_index))
        pbc_pkg::CFG_BOUND_LEFT:     bound_left     <= cfg_wdata;
        pbc_pkg::CFG_BOUND_TOP:      bound_top      <= cfg_wdata;
        pbc_pkg::CFG_BOUND_WIDTH:    bound_width    <= cfg_wdata[30:0];
        pbc_pkg::CFG_BOUND_HEIGHT:   bound_height   <= cfg_wdata[30:0];
        pbc_pkg::CFG_DEFAULT_RADIUS: default_radius <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Disc store.
  assign ram_wdata = cmd.wr_b ? b : a;

  pbc_ram #(
    .WIDTH($bits(pbc_pkg::disc_t)),
    .DEPTH(MAX_DISCS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  // Impulse divider.
  pbc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == pbc_pkg::OP_DIV),
    .num  (kn),
    .den  (n),
    .busy (div_busy),
    .quo  (quo)
  );

  // Per-axis operand selection.
  always_comb begin
    c_sel    = cmd.axis ? a.cy : a.cx;
    v_sel    = cmd.axis ? a.vy : a.vx;
    bnd_sel  = cmd.axis ? bound_top : bound_left;
    span_sel = cmd.axis ? bound_height : bound_width;
    u_sel    = cmd.axis ? u_y : u_x;
  end

  // Shared multiplier operands; the product is registered in prod.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      pbc_pkg::OP_MUL_POS: begin
        mul_a = 34'(v_sel);
        mul_b = 34'({1'b0, elapsed});
      end
      pbc_pkg::OP_SQ_S: begin
        mul_a = 34'(r_sum);
        mul_b = 34'(r_sum);
      end
      pbc_pkg::OP_SQ_X: begin
        mul_a = 34'(m_x);
        mul_b = 34'(m_x);
      end
      pbc_pkg::OP_SQ_Y: begin
        mul_a = 34'(m_y);
        mul_b = 34'(m_y);
      end
      pbc_pkg::OP_N1: begin
        mul_a = 34'(u_x);
        mul_b = 34'(u_x);
      end
      pbc_pkg::OP_N2: begin
        mul_a = 34'(u_y);
        mul_b = 34'(u_y);
      end
      pbc_pkg::OP_N3: begin
        mul_a = 34'(dv_x);
        mul_b = 34'(u_x);
      end
      pbc_pkg::OP_P1: begin
        mul_a = 34'(dv_y);
        mul_b = 34'(u_y);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[65:0];
  end

  // Working registers, one operation per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      pbc_pkg::OP_CAPTURE: begin
        a.cx    <= pos_x;
        a.cy    <= pos_y;
        a.vx    <= vel_x;
        a.vy    <= vel_y;
        a.r     <= (radius == 31'd0) ? default_radius : radius;
        elapsed <= elapsed_ms;
      end
      pbc_pkg::OP_LOAD_A: a <= ram_rdata;
      pbc_pkg::OP_LOAD_B: b <= ram_rdata;
      pbc_pkg::OP_ADD_POS: begin
        if (cmd.axis) begin
          a.cy <= pbc_pkg::sat32(72'(a.cy) + 72'(prod));
        end else begin
          a.cx <= pbc_pkg::sat32(72'(a.cx) + 72'(prod));
        end
      end
      pbc_pkg::OP_WALL1: begin
        w_lo  <= 34'(c_sel) - $signed({3'b000, a.r});
        w_hi  <= 34'(c_sel) + $signed({3'b000, a.r});
        w_bnd <= 34'(bnd_sel);
        w_bh  <= 34'(bnd_sel) + $signed({3'b000, span_sel});
      end
      pbc_pkg::OP_WALL2: begin
        w_under <= w_lo < w_bnd;
        w_over  <= w_hi >= w_bh;
        if (w_lo < w_bnd) begin
          w_d <= (36'(w_bnd) - 36'(w_lo)) <<< 1;
        end else begin
          w_d <= (36'(w_bh) - 36'(w_hi)) <<< 1;
        end
      end
      pbc_pkg::OP_WALL3: begin
        // Reflect off the wall: mirror the centre and reverse the velocity.
        if (w_under || w_over) begin
          if (cmd.axis) begin
            a.cy <= pbc_pkg::sat32(72'(a.cy) + 72'(w_d));
            a.vy <= pbc_pkg::sat32(-72'(a.vy));
          end else begin
            a.cx <= pbc_pkg::sat32(72'(a.cx) + 72'(w_d));
            a.vx <= pbc_pkg::sat32(-72'(a.vx));
          end
        end
      end
      pbc_pkg::OP_DIFF: begin
        d_x   <= 33'(b.cx) - 33'(a.cx);
        d_y   <= 33'(b.cy) - 33'(a.cy);
        dv_x  <= 33'(a.vx) - 33'(b.vx);
        dv_y  <= 33'(a.vy) - 33'(b.vy);
        r_sum <= 32'(a.r) + 32'(b.r);
      end
      pbc_pkg::OP_MAG: begin
        m_x <= d_x[32] ? 33'(-d_x) : 33'(d_x);
        m_y <= d_y[32] ? 33'(-d_y) : 33'(d_y);
      end
      pbc_pkg::OP_GATE: begin
        // Coincident centres, or one axis already beyond the radius sum.
        skip <= (m_x == 33'd0 && m_y == 33'd0) || (m_x > 33'(r_sum)) ||
                (m_y > 33'(r_sum));
      end
      pbc_pkg::OP_SQ_X: sq_s <= prod[63:0];
      pbc_pkg::OP_SQ_Y: sq_a <= prod[63:0];
      pbc_pkg::OP_CONTACT: far <= (65'(sq_a) + 65'(prod[63:0])) > 65'(sq_s);
      pbc_pkg::OP_NORM: begin
        m_x <= m_x >> 1;
        m_y <= m_y >> 1;
      end
      pbc_pkg::OP_DIR: begin
        u_x <= d_x[32] ? -$signed({1'b0, m_x[13:0]}) : $signed({1'b0, m_x[13:0]});
        u_y <= d_y[32] ? -$signed({1'b0, m_y[13:0]}) : $signed({1'b0, m_y[13:0]});
      end
      pbc_pkg::OP_N2: n_a <= prod[27:0];
      pbc_pkg::OP_N3: n   <= 29'(n_a) + 29'(prod[27:0]);
      pbc_pkg::OP_P1: p_a <= $signed(prod[47:0]);
      pbc_pkg::OP_P2: p   <= 49'(p_a) + 49'($signed(prod[47:0]));
      pbc_pkg::OP_KMUL: kn <= p * u_sel;
      pbc_pkg::OP_APPLY: begin
        if (cmd.axis) begin
          a.vy <= pbc_pkg::sat32(72'(a.vy) - 72'(quo));
          b.vy <= pbc_pkg::sat32(72'(b.vy) + 72'(quo));
        end else begin
          a.vx <= pbc_pkg::sat32(72'(a.vx) - 72'(quo));
          b.vx <= pbc_pkg::sat32(72'(b.vx) + 72'(quo));
        end
      end
      default: ;
    endcase
  end

  // Status back to the controller.
  always_comb begin
    stat.skip      = skip;
    stat.far       = far;
    stat.norm_busy = (m_x >= 33'(pbc_pkg::DIR_LIMIT)) ||
                     (m_y >= 33'(pbc_pkg::DIR_LIMIT));
    stat.div_busy  = div_busy;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_zero) begin
        m_tdata <= {7'd0, 128'd0, cmd.emit_cnt, cmd.emit_idx};
      end else begin
        m_tdata <= {7'd0, a.vy, a.vx, a.cy, a.cx, cmd.emit_cnt, cmd.emit_idx};
      end
      m_tuser <= cmd.emit_rej;
      m_tlast <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbc_ctrl.sv =====
// Controller of the disc collision block: sequences add, remove and tick items.
// Depends on pbc_pkg; drives the datapath through command and status structs.
`default_nettype none

module pbc_ctrl #(
  parameter int MAX_DISCS = 16,
  localparam int IW = (MAX_DISCS > 1) ? $clog2(MAX_DISCS) : 1,
  localparam int CW = $clog2(MAX_DISCS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [1:0]        action,
  input  wire logic [4:0]        remove_count,
  output pbc_pkg::dp_cmd_t       cmd,
  input  wire pbc_pkg::dp_stat_t stat,
  output logic [IW-1:0]          ram_addr,
  output logic                   ram_we,
  output logic                   ram_re
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_ADD, ST_REMOVE,
    ST_MV_RD, ST_MV_LD, ST_MV_MUL, ST_MV_ADD, ST_W1, ST_W2, ST_W3, ST_MV_WR,
    ST_PR_RDA, ST_PR_RDB, ST_PR_LDB, ST_DIFF, ST_MAG, ST_GATE,
    ST_SQS, ST_SQX, ST_SQY, ST_CONTACT, ST_CHK, ST_NORM, ST_DIR,
    ST_N1, ST_N2, ST_N3, ST_P1, ST_P2, ST_KMUL, ST_DIV, ST_WAIT,
    ST_WRA, ST_WRB, ST_NEXT,
    ST_RP_RD, ST_RP_LD, ST_RP_EM
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic          axis, axis_next;
  logic [4:0]    rc, rc_next;
  logic [6:0]    shown;

  // Discs reported by a tick.
  assign shown = (7'(count) > 7'(pbc_pkg::REPORT_MAX)) ? 7'(pbc_pkg::REPORT_MAX)
                                                        : 7'(count);

  // Next state, counters and datapath commands.
  always_comb begin
    state_next = state;
    count_next = count;
    i_next     = i;
    j_next     = j;
    axis_next  = axis;
    rc_next    = rc;
    s_tready   = 1'b0;
    ram_addr   = IW'(i);
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    cmd        = '0;
    cmd.op     = pbc_pkg::OP_NOP;
    cmd.axis   = axis;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op  = pbc_pkg::OP_CAPTURE;
          rc_next = remove_count;
          i_next  = '0;
          case (action)
            pbc_pkg::ACT_ADD:    state_next = ST_ADD;
            pbc_pkg::ACT_REMOVE: state_next = ST_REMOVE;
            pbc_pkg::ACT_TICK:   state_next = (count == '0) ? ST_IDLE : ST_MV_RD;
            default:             state_next = ST_IDLE;
          endcase
        end
      end

      ST_ADD: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (7'(count) >= 7'(MAX_DISCS)) begin
            cmd.emit_zero = 1'b1;
            cmd.emit_rej  = 1'b1;
            cmd.emit_cnt  = 5'(count);
          end else begin
            ram_we       = 1'b1;
            ram_addr     = IW'(count);
            cmd.emit_idx = 4'(count);
            cmd.emit_cnt = 5'(count + CW'(1));
            count_next   = count + CW'(1);
          end
          state_next = ST_IDLE;
        end
      end

      ST_REMOVE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_zero = 1'b1;
          if (7'(rc) > 7'(count)) begin
            cmd.emit_rej = 1'b1;
            cmd.emit_cnt = 5'(count);
          end else begin
            count_next   = count - CW'(rc);
            cmd.emit_cnt = 5'(count - CW'(rc));
          end
          state_next = ST_IDLE;
        end
      end

      // Move each disc and reflect it off the walls.
      ST_MV_RD: begin
        ram_re     = 1'b1;
        state_next = ST_MV_LD;
      end
      ST_MV_LD: begin
        cmd.op     = pbc_pkg::OP_LOAD_A;
        axis_next  = 1'b0;
        state_next = ST_MV_MUL;
      end
      ST_MV_MUL: begin
        cmd.op     = pbc_pkg::OP_MUL_POS;
        state_next = ST_MV_ADD;
      end
      ST_MV_ADD: begin
        cmd.op     = pbc_pkg::OP_ADD_POS;
        axis_next  = !axis;
        state_next = axis ? ST_W1 : ST_MV_MUL;
      end
      ST_W1: begin
        cmd.op     = pbc_pkg::OP_WALL1;
        state_next = ST_W2;
      end
      ST_W2: begin
        cmd.op     = pbc_pkg::OP_WALL2;
        state_next = ST_W3;
      end
      ST_W3: begin
        cmd.op     = pbc_pkg::OP_WALL3;
        axis_next  = !axis;
        state_next = axis ? ST_MV_WR : ST_W1;
      end
      ST_MV_WR: begin
        ram_we = 1'b1;
        if (i + CW'(1) == count) begin
          i_next     = '0;
          j_next     = CW'(1);
          state_next = (7'(count) < 7'd2) ? ST_RP_RD : ST_PR_RDA;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_MV_RD;
        end
      end

      // Pair test in index order.
      ST_PR_RDA: begin
        ram_re     = 1'b1;
        state_next = ST_PR_RDB;
      end
      ST_PR_RDB: begin
        ram_re     = 1'b1;
        ram_addr   = IW'(j);
        cmd.op     = pbc_pkg::OP_LOAD_A;
        state_next = ST_PR_LDB;
      end
      ST_PR_LDB: begin
        cmd.op     = pbc_pkg::OP_LOAD_B;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op     = pbc_pkg::OP_DIFF;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.op     = pbc_pkg::OP_MAG;
        state_next = ST_GATE;
      end
      ST_GATE: begin
        cmd.op     = pbc_pkg::OP_GATE;
        state_next = ST_SQS;
      end
      ST_SQS: begin
        if (stat.skip) begin
          state_next = ST_NEXT;
        end else begin
          cmd.op     = pbc_pkg::OP_SQ_S;
          state_next = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd.op     = pbc_pkg::OP_SQ_X;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op     = pbc_pkg::OP_SQ_Y;
        state_next = ST_CONTACT;
      end
      ST_CONTACT: begin
        cmd.op     = pbc_pkg::OP_CONTACT;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        axis_next  = 1'b0;
        state_next = stat.far ? ST_NEXT : ST_NORM;
      end
      ST_NORM: begin
        if (stat.norm_busy) begin
          cmd.op = pbc_pkg::OP_NORM;
        end else begin
          state_next = ST_DIR;
        end
      end
      ST_DIR: begin
        cmd.op     = pbc_pkg::OP_DIR;
        state_next = ST_N1;
      end
      ST_N1: begin
        cmd.op     = pbc_pkg::OP_N1;
        state_next = ST_N2;
      end
      ST_N2: begin
        cmd.op     = pbc_pkg::OP_N2;
        state_next = ST_N3;
      end
      ST_N3: begin
        cmd.op     = pbc_pkg::OP_N3;
        state_next = ST_P1;
      end
      ST_P1: begin
        cmd.op     = pbc_pkg::OP_P1;
        state_next = ST_P2;
      end
      ST_P2: begin
        cmd.op     = pbc_pkg::OP_P2;
        state_next = ST_KMUL;
      end
      ST_KMUL: begin
        cmd.op     = pbc_pkg::OP_KMUL;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op     = pbc_pkg::OP_DIV;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = pbc_pkg::OP_APPLY;
          axis_next  = !axis;
          state_next = axis ? ST_WRA : ST_KMUL;
        end
      end
      ST_WRA: begin
        ram_we     = 1'b1;
        state_next = ST_WRB;
      end
      ST_WRB: begin
        ram_we     = 1'b1;
        ram_addr   = IW'(j);
        cmd.wr_b   = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (j + CW'(1) < count) begin
          j_next     = j + CW'(1);
          state_next = ST_PR_RDA;
        end else if (i + CW'(2) < count) begin
          i_next     = i + CW'(1);
          j_next     = i + CW'(2);
          state_next = ST_PR_RDA;
        end else begin
          i_next     = '0;
          state_next = ST_RP_RD;
        end
      end

      // Report the discs, at most REPORT_MAX of them, one item each.
      ST_RP_RD: begin
        ram_re     = 1'b1;
        state_next = ST_RP_LD;
      end
      ST_RP_LD: begin
        cmd.op     = pbc_pkg::OP_LOAD_A;
        state_next = ST_RP_EM;
      end
      ST_RP_EM: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_idx  = 4'(i);
          cmd.emit_cnt  = 5'(count);
          cmd.emit_last = (7'(i) + 7'd1 == shown);
          i_next        = i + CW'(1);
          state_next    = (7'(i) + 7'd1 == shown) ? ST_IDLE : ST_RP_RD;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      i     <= '0;
      j     <= '0;
      axis  <= 1'b0;
      rc    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      i     <= i_next;
      j     <= j_next;
      axis  <= axis_next;
      rc    <= rc_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/particle_bounce_collide_step.sv =====
// An add or remove result is registered in the ADD or REMOVE state once the output
// register is free. A tick moves each disc and reflects it off the walls, tests each
// pair (ending early when one axis exceeds the radius sum or when out of contact, and
// taking two divisions in contact) and reports the discs. One item at a time; the pair
// loop and the iterative divider set the rate. Reset (synchronous, active high) empties
// the disc table and restores the configuration; stored entries need no clearing.
`default_nettype none

module particle_bounce_collide_step #(
  parameter int MAX_DISCS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, vel_x, vel_y, radius, remove_count, elapsed_ms, zero pad
  input  wire logic [183:0] s_tdata,
  // action
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // particle_index, count_after, out_center_x, out_center_y, out_vel_x,
  // out_vel_y, zero pad
  output logic [143:0]      m_tdata,
  // rejected
  output logic              m_tuser,
  // last_of_run
  output logic              m_tlast
);

  localparam int IW = (MAX_DISCS > 1) ? $clog2(MAX_DISCS) : 1;

  pbc_pkg::dp_cmd_t  cmd;
  pbc_pkg::dp_stat_t stat;
  logic [IW-1:0]     ram_addr;
  logic              ram_we;
  logic              ram_re;

  pbc_ctrl #(
    .MAX_DISCS(MAX_DISCS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .action      (s_tuser),
    .remove_count(s_tdata[163:159]),
    .cmd         (cmd),
    .stat        (stat),
    .ram_addr    (ram_addr),
    .ram_we      (ram_we),
    .ram_re      (ram_re)
  );

  pbc_datapath #(
    .MAX_DISCS(MAX_DISCS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos_x     (s_tdata[31:0]),
    .pos_y     (s_tdata[63:32]),
    .vel_x     (s_tdata[95:64]),
    .vel_y     (s_tdata[127:96]),
    .radius    (s_tdata[158:128]),
    .elapsed_ms(s_tdata[179:164]),
    .cmd       (cmd),
    .stat      (stat),
    .ram_addr  (ram_addr),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // A rejected item is always the only, and so the last, result of its item.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tlast)
    else $error("rejected result without last_of_run");

  // A rejected result carries index zero and no disc state.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[3:0] == 4'd0) && (m_tdata[136:9] == 128'd0))
    else $error("rejected result carries disc data");

  // The table never holds more discs than it has room for.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (MAX_DISCS > 31) || (m_tdata[8:4] <= 5'(MAX_DISCS)))
    else $error("count_after beyond table size");

  // An add or remove item keeps the input closed while it is worked on.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == pbc_pkg::ACT_ADD || s_tuser == pbc_pkg::ACT_REMOVE) |=> !s_tready)
    else $error("input reopened while an item is in work");

endmodule

`default_nettype wire
